[rtl/qrrs_pkg.sv]
// Shared types and codes for the quadratic real-root solver.
// No dependencies.
package qrrs_pkg;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic fault;    // leading coefficient is zero
    logic no_root;  // discriminant below zero
    logic single;   // discriminant exactly zero
  } qrrs_flags_t;

endpackage

[rtl/qrrs_disc.sv]
// Coefficient split, products and discriminant: three register stages.
// Depends on qrrs_pkg.
module qrrs_disc #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [W-1:0]          coef_a_i,
  input  logic [W-1:0]          coef_b_i,
  input  logic [W-1:0]          coef_c_i,
  output logic                  valid_o,
  output logic [2*W+1:0]        d_o,
  output qrrs_pkg::qrrs_flags_t flags_o,
  output logic                  na_o,
  output logic [W-1:0]          ma_o,
  output logic                  nb_o,
  output logic [W-1:0]          mb_o
);

  localparam int unsigned DW = 2 * W + 2;

  logic           v0_q, v1_q, v2_q;
  logic           na0_q, nb0_q, nc0_q;
  logic [W-1:0]   ma0_q, mb0_q, mc0_q;
  logic           na1_q, nb1_q, nc1_q, fault1_q;
  logic [W-1:0]   ma1_q, mb1_q;
  logic [2*W-1:0] bb1_q, ac1_q;
  logic [DW-1:0]  bbx, fac, sum;
  logic [DW:0]    diff;
  logic           same;
  logic [DW-1:0]  d2_q;
  logic           na2_q, nb2_q;
  logic [W-1:0]   ma2_q, mb2_q;
  qrrs_pkg::qrrs_flags_t flags2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // Stage 0: sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na0_q <= coef_a_i[W-1];
      nb0_q <= coef_b_i[W-1];
      nc0_q <= coef_c_i[W-1];
      ma0_q <= coef_a_i[W-1] ? (~coef_a_i + W'(1)) : coef_a_i;
      mb0_q <= coef_b_i[W-1] ? (~coef_b_i + W'(1)) : coef_b_i;
      mc0_q <= coef_c_i[W-1] ? (~coef_c_i + W'(1)) : coef_c_i;
    end
  end

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb1_q    <= (2*W)'(mb0_q) * (2*W)'(mb0_q);
      ac1_q    <= (2*W)'(ma0_q) * (2*W)'(mc0_q);
      na1_q    <= na0_q;
      nb1_q    <= nb0_q;
      nc1_q    <= nc0_q;
      ma1_q    <= ma0_q;
      mb1_q    <= mb0_q;
      fault1_q <= (ma0_q == '0);
    end
  end

  // Stage 2: D = B*B - 4AC, the 4AC term subtracts when a and c share a sign
  always_comb begin
    bbx  = DW'(bb1_q);
    fac  = DW'(ac1_q) << 2;
    same = (na1_q == nc1_q);
    diff = {1'b0, bbx} - {1'b0, fac};
    sum  = bbx + fac;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q             <= (same && diff[DW]) ? '0 : (same ? diff[DW-1:0] : sum);
      flags2_q.fault   <= fault1_q;
      flags2_q.no_root <= same && diff[DW];
      flags2_q.single  <= 1'b0;
      na2_q            <= na1_q;
      nb2_q            <= nb1_q;
      ma2_q            <= ma1_q;
      mb2_q            <= mb1_q;
    end
  end

  assign valid_o = v2_q;
  assign d_o     = d2_q;
  assign flags_o = flags2_q;
  assign na_o    = na2_q;
  assign ma_o    = ma2_q;
  assign nb_o    = nb2_q;
  assign mb_o    = mb2_q;

endmodule

[rtl/qrrs_sqrt.sv]
// Pipelined floor square root, one result bit per register stage.
// No package dependencies; sideband data travels with each item.
module qrrs_sqrt #(
  parameter int unsigned XW     = 98,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [XW-1:0]     x_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [XW/2-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned SW = XW / 2;
  localparam int unsigned RW = SW + 2;

  logic              v_q    [SW];
  logic [XW-1:0]     x_q    [SW];
  logic [RW-1:0]     rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic              vin;
    logic [XW-1:0]     xin;
    logic [RW-1:0]     rin, rsh, trial;
    logic [SW-1:0]     qin;
    logic [SIDE_W-1:0] sin;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign xin = x_i;
      assign rin = '0;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[j-1];
      assign xin = x_q[j-1];
      assign rin = rem_q[j-1];
      assign qin = root_q[j-1];
      assign sin = side_q[j-1];
    end

    // bring down the next bit pair and try root*4+1
    always_comb begin
      rsh   = {rin[SW-1:0], xin[XW-1 -: 2]};
      trial = {qin, 2'b01};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j]    <= xin << 2;
        side_q[j] <= sin;
        if (rsh >= trial) begin
          rem_q[j]  <= rsh - trial;
          root_q[j] <= {qin[SW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rsh;
          root_q[j] <= {qin[SW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

[rtl/qrrs_div.sv]
// Pipelined restoring divider: an input register, then one quotient bit per stage.
// No package dependencies; sideband data travels with each item.
module qrrs_div #(
  parameter int unsigned NW     = 50,
  parameter int unsigned MW     = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     n_i,
  input  logic [MW-1:0]     m_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NW-1:0]     q_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RW = MW + 1;

  logic              v_q    [NW+1];
  logic [NW-1:0]     n_q    [NW+1];
  logic [MW-1:0]     m_q    [NW+1];
  logic [RW-1:0]     rem_q  [NW+1];
  logic [NW-1:0]     quo_q  [NW+1];
  logic [SIDE_W-1:0] side_q [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]    <= n_i;
      m_q[0]    <= m_i;
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 1; j <= NW; j++) begin : g_stage
    logic [RW-1:0] rsh;

    assign rsh = {rem_q[j-1][MW-1:0], n_q[j-1][NW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]    <= n_q[j-1] << 1;
        m_q[j]    <= m_q[j-1];
        side_q[j] <= side_q[j-1];
        if (rsh >= {1'b0, m_q[j-1]}) begin
          rem_q[j] <= rsh - {1'b0, m_q[j-1]};
          quo_q[j] <= {quo_q[j-1][NW-2:0], 1'b1};
        end else begin
          rem_q[j] <= rsh;
          quo_q[j] <= {quo_q[j-1][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[NW];
  assign q_o     = quo_q[NW];
  assign side_o  = side_q[NW];

endmodule

[rtl/quadratic_real_root_solver.sv]
// Quadratic real-root solver, Q-format coefficients in, clamped roots out.
// Pipeline: discriminant stages, bit-per-stage square root, numerator register,
// bit-per-stage dividers, output register. Throughput: one item every cycle.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_ni, async, active low) clears all valid bits; data is not reset.
module quadratic_real_root_solver #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] coef_a_i,
  input  logic [VALUE_WIDTH-1:0] coef_b_i,
  input  logic [VALUE_WIDTH-1:0] coef_c_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             root_count_o,
  output logic [VALUE_WIDTH-1:0] plus_root_o,
  output logic [VALUE_WIDTH-1:0] minus_root_o,
  output logic                   zero_leading_fault_o,
  output logic                   root_saturated_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned DW    = 2 * W + 2;
  localparam int unsigned XW    = DW + 2 * F;
  localparam int unsigned SW    = XW / 2;
  localparam int unsigned NMW   = W + F + 2;
  localparam int unsigned NSW   = NMW + 1;
  localparam int unsigned SQ_SW = 2 * W + 5;
  localparam logic [NMW-1:0] LIM = NMW'(1) << (W - 1);

  logic en;

  // disc stage outputs
  logic                  dv;
  logic [DW-1:0]         dd;
  qrrs_pkg::qrrs_flags_t dflags;
  logic                  dna, dnb;
  logic [W-1:0]          dma, dmb;

  // sqrt outputs
  logic                  sv;
  logic [SW-1:0]         sroot;
  logic [SQ_SW-1:0]      sside;
  qrrs_pkg::qrrs_flags_t sflags;
  logic                  sna, snb;
  logic [W-1:0]          sma, smb;

  // numerator stage
  logic [NSW-1:0]        nbase, np_d, nm_d;
  logic                  nv_q, nna_q;
  logic [NSW-1:0]        np_q, nm_q;
  logic [W-1:0]          nma_q;
  qrrs_pkg::qrrs_flags_t nflags_q;
  logic [NMW-1:0]        pmag, mmag;

  // divider outputs
  logic                  qv, qv_m;
  logic [NMW-1:0]        qp, qm;
  logic [4:0]            qside;
  logic                  qsm;
  qrrs_pkg::qrrs_flags_t qflags;
  logic                  qna, qsp;

  // output register
  logic [W:0]            cp, cm;
  logic                  out_valid_q;
  logic [1:0]            cnt_d, cnt_q;
  logic [W-1:0]          plus_d, plus_q, minus_d, minus_q;
  logic                  fault_d, fault_q, sat_d, sat_q;

  function automatic logic [W:0] clamp(input logic neg, input logic [NMW-1:0] q);
    logic [NMW-1:0] mag;
    logic           sat;
    mag = q;
    sat = 1'b0;
    if (!neg) begin
      if (q > LIM - NMW'(1)) begin
        sat = 1'b1;
        mag = LIM - NMW'(1);
      end
      return {sat, mag[W-1:0]};
    end
    if (q > LIM) begin
      sat = 1'b1;
      mag = LIM;
    end
    return {sat, (~mag[W-1:0]) + W'(1)};
  endfunction

  // whole pipeline advances unless a result is held at the output
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  qrrs_disc #(.W(W)) u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (dv),
    .d_o      (dd),
    .flags_o  (dflags),
    .na_o     (dna),
    .ma_o     (dma),
    .nb_o     (dnb),
    .mb_o     (dmb)
  );

  qrrs_sqrt #(.XW(XW), .SIDE_W(SQ_SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv),
    .x_i     (XW'(dd) << (2 * F)),
    .side_i  ({dflags, dna, dnb, dma, dmb}),
    .valid_o (sv),
    .root_o  (sroot),
    .side_o  (sside)
  );

  assign {sflags, sna, snb, sma, smb} = sside;

  // -B scaled to the root's fraction, then plus and minus the square root
  always_comb begin
    nbase = NSW'(smb) << F;
    if (!snb) begin
      nbase = ~nbase + NSW'(1);
    end
    np_d = nbase + NSW'(sroot);
    nm_d = nbase - NSW'(sroot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en) begin
      nv_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q            <= np_d;
      nm_q            <= nm_d;
      nma_q           <= sma;
      nna_q           <= sna;
      nflags_q.fault  <= sflags.fault;
      nflags_q.no_root <= sflags.no_root;
      nflags_q.single <= (sroot == '0);
    end
  end

  assign pmag = np_q[NSW-1] ? NMW'(~np_q + NSW'(1)) : np_q[NMW-1:0];
  assign mmag = nm_q[NSW-1] ? NMW'(~nm_q + NSW'(1)) : nm_q[NMW-1:0];

  qrrs_div #(.NW(NMW), .MW(W + 1), .SIDE_W(5)) u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv_q),
    .n_i     (pmag),
    .m_i     ({nma_q, 1'b0}),
    .side_i  ({nflags_q, nna_q, np_q[NSW-1]}),
    .valid_o (qv),
    .q_o     (qp),
    .side_o  (qside)
  );

  qrrs_div #(.NW(NMW), .MW(W + 1), .SIDE_W(1)) u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nv_q),
    .n_i     (mmag),
    .m_i     ({nma_q, 1'b0}),
    .side_i  (nm_q[NSW-1]),
    .valid_o (qv_m),
    .q_o     (qm),
    .side_o  (qsm)
  );

  assign {qflags, qna, qsp} = qside;

  always_comb begin
    cp      = clamp(qsp ^ qna, qp);
    cm      = clamp(qsm ^ qna, qm);
    cnt_d   = qrrs_pkg::CNT_NONE;
    plus_d  = '0;
    minus_d = '0;
    fault_d = qflags.fault;
    sat_d   = 1'b0;
    priority if (qflags.fault || qflags.no_root) begin
      cnt_d = qrrs_pkg::CNT_NONE;
    end else if (qflags.single) begin
      cnt_d   = qrrs_pkg::CNT_ONE;
      plus_d  = cp[W-1:0];
      minus_d = cp[W-1:0];
      sat_d   = cp[W];
    end else begin
      cnt_d   = qrrs_pkg::CNT_TWO;
      plus_d  = cp[W-1:0];
      minus_d = cm[W-1:0];
      sat_d   = cp[W] | cm[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= qv & qv_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q   <= cnt_d;
      plus_q  <= plus_d;
      minus_q <= minus_d;
      fault_q <= fault_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign root_count_o         = cnt_q;
  assign plus_root_o          = plus_q;
  assign minus_root_o         = minus_q;
  assign zero_leading_fault_o = fault_q;
  assign root_saturated_o     = sat_q;

`ifndef SYNTH
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o == qrrs_pkg::CNT_NONE |->
      plus_root_o == '0 && minus_root_o == '0 && !root_saturated_o)
    else $error("no-root result carries nonzero data");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_leading_fault_o |-> root_count_o == qrrs_pkg::CNT_NONE)
    else $error("fault with roots reported");

  a_single_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && root_count_o == qrrs_pkg::CNT_ONE |-> plus_root_o == minus_root_o)
    else $error("single root differs between fields");

  a_dividers_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qv == qv_m)
    else $error("divider lanes out of step");
`endif

endmodule

[sim/quadratic_real_root_solver_tb.sv]
// Self-checking testbench for quadratic_real_root_solver: directed table, then random items.
// Uses the qrrs_pkg package and the block itself; expected roots come from an in-bench predictor.
module quadratic_real_root_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned NumRandom  = 1700;

  typedef struct packed {
    logic [1:0]  count;
    logic [31:0] plus;
    logic [31:0] minus;
    logic        fault;
    logic        sat;
  } roots_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        known;
    roots_t      res;
  } coef_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] coef_a_i;
  logic [31:0] coef_b_i;
  logic [31:0] coef_c_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  root_count_o;
  logic [31:0] plus_root_o;
  logic [31:0] minus_root_o;
  logic        zero_leading_fault_o;
  logic        root_saturated_o;

  roots_t      pending_roots[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  logic        calm;

  quadratic_real_root_solver dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 55; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Divide toward zero, then clamp to the signed 32-bit range.
  function automatic logic [31:0] clamp_root(logic signed [127:0] n, logic signed [127:0] den,
                                             inout logic sat);
    logic signed [127:0] q;
    q = n / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    roots_t r;
    logic signed [127:0] sa, sb, sc, disc, s, base, den;
    logic sat;
    r = '0;
    sat = 1'b0;
    sa = 128'(signed'(a));
    sb = 128'(signed'(b));
    sc = 128'(signed'(c));
    if (a == '0) begin
      r.fault = 1'b1;
      return r;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc < 0) return r;
    s    = signed'(floor_sqrt(disc << 32));
    base = -(sb <<< 16);
    den  = 2 * sa;
    if (disc == 0) begin
      r.count = qrrs_pkg::CNT_ONE;
      r.plus  = clamp_root(base, den, sat);
      r.minus = r.plus;
    end else begin
      r.count = qrrs_pkg::CNT_TWO;
      r.plus  = clamp_root(base + s, den, sat);
      r.minus = clamp_root(base - s, den, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  // Drive one coefficient set; random idle cycles first unless in the calm stretch.
  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic known, roots_t res);
    roots_t want;
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i   <= a;
    coef_b_i   <= b;
    coef_c_i   <= c;
    do @(posedge clk_i); while (!in_ready_o);
    want = solve_quadratic(a, b, c);
    if (known && want !== res)
      $error("table row a=%h b=%h c=%h disagrees with predictor", a, b, c);
    pending_roots.push_back(known ? res : want);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= calm || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    roots_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_roots.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        w = pending_roots.pop_front();
        if (root_count_o !== w.count) begin
          $error("root_count exp %0d got %0d", w.count, root_count_o); fail_count++;
        end
        if (plus_root_o !== w.plus) begin
          $error("plus_root exp %h got %h", w.plus, plus_root_o); fail_count++;
        end
        if (minus_root_o !== w.minus) begin
          $error("minus_root exp %h got %h", w.minus, minus_root_o); fail_count++;
        end
        if (zero_leading_fault_o !== w.fault) begin
          $error("zero_leading_fault exp %b got %b", w.fault, zero_leading_fault_o);
          fail_count++;
        end
        if (root_saturated_o !== w.sat) begin
          $error("root_saturated exp %b got %b", w.sat, root_saturated_o); fail_count++;
        end
      end
    end
  end

  // Count cycles without any transfer; bail out on a hang.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_field(int unsigned mode);
    case (mode)
      0:       return $urandom();
      1:       return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
      2:       return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'(signed'($urandom_range(0, 16)) - 8) <<< 16;
    endcase
  endfunction

  initial begin
    coef_row_t   rows[$];
    roots_t      none;
    logic [31:0] a, b, c;
    int          p, k;
    none         = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    coef_a_i     = '0;
    coef_b_i     = '0;
    coef_c_i     = '0;

    // zero leading coefficient, negative, zero and positive discriminant
    rows.push_back('{32'h0, 32'h0001_0000, 32'h0002_0000, 1'b1,
                     '{qrrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b1, 1'b0}});
    rows.push_back('{32'h0, 32'hffff_ffff, 32'h8000_0000, 1'b1,
                     '{qrrs_pkg::CNT_NONE, 32'h0, 32'h0, 1'b1, 1'b0}});
    rows.push_back('{32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1, none});
    rows.push_back('{32'h0001_0000, 32'hfffe_0000, 32'h0001_0000, 1'b1,
                     '{qrrs_pkg::CNT_ONE, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0}});
    rows.push_back('{32'h0001_0000, 32'h0, 32'hfffc_0000, 1'b1,
                     '{qrrs_pkg::CNT_TWO, 32'h0002_0000, 32'hfffe_0000, 1'b0, 1'b0}});
    // extremes and saturation, checked by the predictor
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, none});
    rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, none});
    rows.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, none});
    rows.push_back('{32'h0000_0001, 32'h7fff_ffff, 32'h0, 1'b0, none});
    rows.push_back('{32'hffff_ffff, 32'h8000_0000, 32'h0, 1'b0, none});
    rows.push_back('{32'h0000_0001, 32'h0, 32'h8000_0000, 1'b0, none});
    rows.push_back('{32'hffff_ffff, 32'h0, 32'h7fff_ffff, 1'b0, none});
    rows.push_back('{32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b0, none});
    rows.push_back('{32'h8000_0000, 32'h0, 32'h0, 1'b0, none});
    rows.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none});
    rows.push_back('{32'h0000_0001, 32'h0000_0002, 32'h0000_0001, 1'b0, none});
    rows.push_back('{32'hfffe_0000, 32'h0003_0000, 32'h0005_0000, 1'b0, none});

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].known, rows[i].res);

    for (int n = 0; n < NumRandom; n++) begin
      calm = (n >= 700 && n < 1000);
      if ($urandom_range(3) == 0) begin
        // exact zero discriminant: A=p, B=2pk, C=pk^2
        p = $urandom_range(1, 2000) * ($urandom_range(1) ? 1 : -1);
        k = int'($urandom_range(0, 400)) - 200;
        a = 32'(p);
        b = 32'(2 * p * k);
        c = 32'(p * k * k);
      end else begin
        a = pick_field($urandom_range(3));
        b = pick_field($urandom_range(3));
        c = pick_field($urandom_range(3));
        if ($urandom_range(40) == 0) a = '0;
      end
      send_coefs(a, b, c, 1'b0, none);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
